### rtl/arc_vtx_pkg.sv
// Shared types, constants and sine polynomial coefficients for the arc vertex generator.
package arc_vtx_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int MAX_SECTIONS_DEF = 63;
	localparam logic [5:0] SECTION_COUNT_RESET = 6'd16;

	// Coefficients of the odd sine polynomial, all in Q30.
	localparam logic [30:0] POLY_A = 31'd1686629713;
	localparam logic [30:0] POLY_B = 31'd688904866;
	localparam logic [30:0] POLY_C = 31'd76016977;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [61:0] ROUND_HALF = 62'h2000_0000;

	typedef enum logic [2:0] {
		OP_SQUARE,
		OP_POLY_T,
		OP_POLY_U,
		OP_SINE,
		OP_SCALE
	} cell_op_t;

	localparam int NUM_CELLS = 5;
	localparam cell_op_t CELL_OPS [NUM_CELLS] = '{OP_SQUARE, OP_POLY_T, OP_POLY_U, OP_SINE, OP_SCALE};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_NEXT,
		ST_WAIT
	} seq_state_t;

	typedef struct packed {
		logic [30:0] z;
		logic [30:0] z2;
		logic [31:0] acc;
		logic        neg;
	} lane_t;

	typedef struct packed {
		logic               last;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        r;
		lane_t              lx;
		lane_t              ly;
	} point_t;

endpackage

### rtl/arc_vtx_cell.sv
// One cell of the evaluation chain: a multiply-and-shift step on the cosine and sine lanes.
module arc_vtx_cell
	import arc_vtx_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cell_op_t op,
	input  logic     in_valid,
	input  point_t   in_pt,
	output logic     out_valid,
	output point_t   out_pt
);

	logic   valid_q;
	point_t pt_q;
	point_t pt_d;

	function automatic lane_t lane_step(cell_op_t o, lane_t l, logic [30:0] r);
		logic [30:0] a;
		logic [30:0] b;
		logic [61:0] p;
		logic [31:0] sh;
		lane_t       res;
		res = l;
		a = l.z;
		b = l.acc[30:0];
		case (o)
			OP_SQUARE: begin
				a = l.z;
				b = l.z;
			end
			OP_POLY_T: begin
				a = l.z2;
				b = POLY_C;
			end
			OP_POLY_U: begin
				a = l.z2;
				b = l.acc[30:0];
			end
			OP_SINE: begin
				a = l.z;
				b = l.acc[30:0];
			end
			OP_SCALE: begin
				a = r;
				b = l.acc[30:0];
			end
			default: begin
				a = l.z;
				b = l.acc[30:0];
			end
		endcase
		p = 62'(a) * 62'(b);
		if (o == OP_SCALE) begin
			p = p + ROUND_HALF;
		end
		sh = p[61:30];
		case (o)
			OP_SQUARE: res.z2 = sh[30:0];
			OP_POLY_T: res.acc = 32'(POLY_B) - sh;
			OP_POLY_U: res.acc = 32'(POLY_A) - sh;
			default:   res.acc = sh;
		endcase
		return res;
	endfunction

	always_comb begin
		pt_d = in_pt;
		pt_d.lx = lane_step(op, in_pt.lx, in_pt.r);
		pt_d.ly = lane_step(op, in_pt.ly, in_pt.r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		pt_q <= pt_d;
	end

	assign out_valid = valid_q;
	assign out_pt = pt_q;

endmodule

### rtl/arc_vtx_seq.sv
// Arc sequencer: step division, angle walk and issue of one point at a time into the chain.
module arc_vtx_seq
	import arc_vtx_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [5:0]   section_count,
	input  logic         arc_valid,
	output logic         arc_ready,
	input  logic [31:0]  center_x,
	input  logic [31:0]  center_y,
	input  logic [30:0]  arc_radius,
	input  logic [15:0]  begin_angle,
	input  logic [15:0]  end_angle,
	input  logic         clockwise,
	input  logic         point_done,
	output logic         issue_valid,
	output point_t       issue_pt
);

	localparam int SEC_W = $clog2(MAX_SECTIONS + 1);
	localparam int CNT_W = $clog2(ANGLE_BITS + 1);
	localparam logic [ANGLE_BITS:0] TURN = (ANGLE_BITS + 1)'(1) << ANGLE_BITS;

	seq_state_t state_q, state_d;

	logic [CNT_W-1:0]      cnt_q;
	logic [SEC_W:0]        rem_q;
	logic [ANGLE_BITS:0]   quo_q;
	logic [SEC_W-1:0]      n_q;
	logic [SEC_W-1:0]      k_q;
	logic [ANGLE_BITS:0]   rot_q;
	logic [ANGLE_BITS-1:0] step_q;
	logic [ANGLE_BITS-1:0] begin_q;
	logic [ANGLE_BITS-1:0] end_q;
	logic                  cw_q;
	logic                  last_q;
	logic signed [31:0]    cx_q;
	logic signed [31:0]    cy_q;
	logic [30:0]           r_q;

	logic [SEC_W-1:0]      n_clamp;
	logic [SEC_W:0]        rem_shift;
	logic                  rem_ge;
	logic [SEC_W:0]        rem_new;
	logic [ANGLE_BITS:0]   quo_new;
	logic [ANGLE_BITS-1:0] diff;
	logic                  interior;
	logic [ANGLE_BITS-1:0] angle;
	logic [31:0]           phase;

	function automatic lane_t make_lane(logic [31:0] ph);
		lane_t l;
		l.z = {1'b0, ph[29:0]};
		if (ph[30]) begin
			l.z = Q30_ONE - l.z;
		end
		l.neg = ph[31];
		l.z2 = '0;
		l.acc = '0;
		return l;
	endfunction

	always_comb begin
		if (section_count == 6'd0) begin
			n_clamp = SEC_W'(1);
		end else if (32'(section_count) > 32'(MAX_SECTIONS)) begin
			n_clamp = SEC_W'(MAX_SECTIONS);
		end else begin
			n_clamp = SEC_W'(section_count);
		end
	end

	// Restoring division of one full turn by the section count, one quotient bit a cycle.
	always_comb begin
		rem_shift = {rem_q[SEC_W-1:0], (cnt_q == '0)};
		rem_ge = rem_shift >= {1'b0, n_q};
		rem_new = rem_ge ? rem_shift - {1'b0, n_q} : rem_shift;
		quo_new = {quo_q[ANGLE_BITS-1:0], rem_ge};
	end

	always_comb begin
		diff = end_q - begin_q;
		if (k_q >= n_q) begin
			interior = 1'b0;
		end else if (cw_q) begin
			interior = (TURN - rot_q) > {1'b0, diff};
		end else begin
			interior = rot_q < {1'b0, diff};
		end
		if (!interior) begin
			angle = end_q;
		end else if (cw_q) begin
			angle = begin_q - rot_q[ANGLE_BITS-1:0];
		end else begin
			angle = begin_q + rot_q[ANGLE_BITS-1:0];
		end
		phase = 32'(angle) << (32 - ANGLE_BITS);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (arc_valid) state_d = ST_DIV;
			ST_DIV:  if (cnt_q == CNT_W'(ANGLE_BITS)) state_d = ST_NEXT;
			ST_NEXT: state_d = ST_WAIT;
			ST_WAIT: begin
				if (point_done) begin
					state_d = last_q ? ST_IDLE : ST_NEXT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		arc_ready = (state_q == ST_IDLE);
		issue_valid = (state_q == ST_NEXT);
		issue_pt.last = !interior;
		issue_pt.cx = cx_q;
		issue_pt.cy = cy_q;
		issue_pt.r = r_q;
		issue_pt.lx = make_lane(phase + 32'h4000_0000);
		issue_pt.ly = make_lane(phase);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			k_q <= '0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					k_q <= SEC_W'(1);
				end
				ST_NEXT: begin
					last_q <= !interior;
				end
				ST_WAIT: begin
					if (point_done && !last_q) begin
						k_q <= k_q + SEC_W'(1);
					end
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && arc_valid) begin
			n_q <= n_clamp;
			rem_q <= '0;
			quo_q <= '0;
			begin_q <= ANGLE_BITS'(begin_angle);
			end_q <= ANGLE_BITS'(end_angle);
			cw_q <= clockwise;
			cx_q <= center_x;
			cy_q <= center_y;
			r_q <= arc_radius;
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_new;
			quo_q <= quo_new;
			step_q <= quo_new[ANGLE_BITS-1:0];
			rot_q <= {1'b0, quo_new[ANGLE_BITS-1:0]};
		end
		if (state_q == ST_WAIT && point_done) begin
			rot_q <= rot_q + {1'b0, step_q};
		end
	end

endmodule

### rtl/arc_vertex_generator.sv
// Top level of the arc vertex generator: configuration, sequencer, cell chain and output stage.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------------
//  s_axis   | in        | tdata: center_x, center_y, arc_radius, begin_angle,
//           |           |        end_angle; tuser: clockwise
//  m_axis   | out       | tdata: point_x, point_y; tlast: last_point
//  cfg      | in        | data: section_count (always ready)
//
// An arc first runs the step division in the sequencer; then each point passes through the
// issue state, the five chain cells and the output register, and waits there on
// m_axis_tready. Points go through the chain one at a time.
// A new arc is accepted only after the end point transaction has completed.
// Reset clears the control state and sets section_count to 16.
module arc_vertex_generator
	import arc_vtx_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// center_x[31:0], center_y[63:32], arc_radius[94:64], begin_angle[110:95],
	// end_angle[126:111], zero fill[127]
	input  logic [127:0] s_axis_tdata,
	// clockwise[0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// point_x[31:0], point_y[63:32]
	output logic [63:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [5:0]   cfg_data
);

	logic [5:0] section_count_q;
	logic       issue_valid;
	point_t     issue_pt;
	logic       point_done;

	logic   chain_valid [NUM_CELLS+1];
	point_t chain_pt    [NUM_CELLS+1];

	logic               tvalid_q;
	logic               tlast_q;
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	logic signed [31:0] px_d;
	logic signed [31:0] py_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_count_q <= SECTION_COUNT_RESET;
		end else if (cfg_valid) begin
			section_count_q <= cfg_data;
		end
	end

	assign point_done = tvalid_q && m_axis_tready;

	arc_vtx_seq #(
		.ANGLE_BITS  (ANGLE_BITS),
		.MAX_SECTIONS(MAX_SECTIONS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.section_count(section_count_q),
		.arc_valid    (s_axis_tvalid),
		.arc_ready    (s_axis_tready),
		.center_x     (s_axis_tdata[31:0]),
		.center_y     (s_axis_tdata[63:32]),
		.arc_radius   (s_axis_tdata[94:64]),
		.begin_angle  (s_axis_tdata[110:95]),
		.end_angle    (s_axis_tdata[126:111]),
		.clockwise    (s_axis_tuser),
		.point_done   (point_done),
		.issue_valid  (issue_valid),
		.issue_pt     (issue_pt)
	);

	assign chain_valid[0] = issue_valid;
	assign chain_pt[0] = issue_pt;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		arc_vtx_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (CELL_OPS[i]),
			.in_valid (chain_valid[i]),
			.in_pt    (chain_pt[i]),
			.out_valid(chain_valid[i+1]),
			.out_pt   (chain_pt[i+1])
		);
	end

	function automatic logic signed [31:0] add_sat(logic signed [31:0] c, lane_t l);
		logic signed [33:0] off;
		logic signed [33:0] sum;
		off = $signed({2'b00, l.acc});
		if (l.neg) begin
			off = -off;
		end
		sum = 34'(c) + off;
		if (sum > 34'sh0_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (sum < -34'sh0_8000_0000) begin
			return 32'sh8000_0000;
		end
		return sum[31:0];
	endfunction

	always_comb begin
		px_d = add_sat(chain_pt[NUM_CELLS].cx, chain_pt[NUM_CELLS].lx);
		py_d = add_sat(chain_pt[NUM_CELLS].cy, chain_pt[NUM_CELLS].ly);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (chain_valid[NUM_CELLS]) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chain_valid[NUM_CELLS]) begin
			px_q <= px_d;
			py_q <= py_d;
			tlast_q <= chain_pt[NUM_CELLS].last;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata = {py_q, px_q};
	assign m_axis_tlast = tlast_q;

endmodule

### bench/testbench.sv
// Self-checking testbench for the arc vertex generator: directed rows, then random arcs.
module testbench
	import arc_vtx_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        r;
		logic [15:0]        b;
		logic [15:0]        e;
		logic               cw;
	} arc_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        last;
	} vertex_t;

	typedef struct {
		arc_t        arc;
		bit          typed;
		logic [31:0] tx;
		logic [31:0] ty;
	} row_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [63:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [5:0]   cfg_data = '0;

	vertex_t     vertex_q[$];
	logic [5:0]  sections = SECTION_COUNT_RESET;
	int          fail_count = 0;
	int          burst_left = 0;
	int          rx_hold = 0;
	int          rx_mode = 0;
	int          rx_left = 0;
	int          cycle_count = 0;

	arc_vertex_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Sine of a 32-bit turn fraction in Q30, odd polynomial per quadrant.
	function automatic longint signed sine_q30(logic [31:0] phase);
		logic [63:0] z, z2, t, u, s;
		z = {34'b0, phase[29:0]};
		if (phase[30])
			z = 64'(Q30_ONE) - z;
		z2 = (z * z) >> 30;
		t = 64'(POLY_B) - ((z2 * 64'(POLY_C)) >> 30);
		u = 64'(POLY_A) - ((z2 * t) >> 30);
		s = (z * u) >> 30;
		return phase[31] ? -longint'(s) : longint'(s);
	endfunction

	function automatic longint signed radius_offset(logic [30:0] r, longint signed s);
		logic [63:0] mag, m;
		mag = (s < 0) ? 64'(-s) : 64'(s);
		m = (64'(r) * mag + 64'(ROUND_HALF)) >> 30;
		return (s < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [31:0] clamp32(longint signed v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic vertex_t vertex_at(arc_t a, logic [15:0] angle, logic last);
		vertex_t v;
		logic [31:0] phase;
		phase = {angle, 16'b0};
		v.x = clamp32(longint'(a.cx) + radius_offset(a.r, sine_q30(phase + 32'h4000_0000)));
		v.y = clamp32(longint'(a.cy) + radius_offset(a.r, sine_q30(phase)));
		v.last = last;
		return v;
	endfunction

	// Walks the arc in whole steps, then appends the exact end point.
	task automatic predict_arc(arc_t a);
		int unsigned n;
		logic [15:0] step, diff;
		logic [31:0] rot;
		n = (sections == 0) ? 1 : sections;
		if (n > MAX_SECTIONS_DEF)
			n = MAX_SECTIONS_DEF;
		step = 16'((32'd65536 / n) & 32'hFFFF);
		diff = a.e - a.b;
		for (int unsigned k = 1; k < n; k++) begin
			rot = k * 32'(step);
			if (a.cw) begin
				if (!(32'd65536 - rot > 32'(diff)))
					break;
				vertex_q.push_back(vertex_at(a, a.b - rot[15:0], 1'b0));
			end else begin
				if (!(rot < 32'(diff)))
					break;
				vertex_q.push_back(vertex_at(a, a.b + rot[15:0], 1'b0));
			end
		end
		vertex_q.push_back(vertex_at(a, a.e, 1'b1));
	endtask

	task automatic send_arc(row_t row);
		vertex_t v;
		if (burst_left == 0) begin
			s_axis_tvalid = 0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 10);
		end
		s_axis_tdata = {1'b0, row.arc.e, row.arc.b, row.arc.r, row.arc.cy, row.arc.cx};
		s_axis_tuser = row.arc.cw;
		s_axis_tvalid = 1;
		do @(posedge clk); while (!s_axis_tready);
		if (row.typed) begin
			v.x = row.tx;
			v.y = row.ty;
			v.last = 1'b1;
			vertex_q.push_back(v);
		end else begin
			predict_arc(row.arc);
		end
		burst_left--;
		@(negedge clk);
	endtask

	// Drains every expected point, then lets the sequencer settle.
	task automatic drain();
		s_axis_tvalid = 0;
		burst_left = 0;
		wait (vertex_q.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_sections(logic [5:0] value);
		cfg_data = value;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		sections = value;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic arc_t random_arc();
		arc_t a;
		a.cx = $urandom;
		a.cy = $urandom;
		a.r = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 32'h3_0000)) : 31'($urandom);
		a.b = 16'($urandom);
		a.e = ($urandom_range(0, 4) == 0) ? a.b : 16'($urandom);
		a.cw = 1'($urandom);
		return a;
	endfunction

	// Receiver readiness: stretches of full, random and sparse acceptance, plus one long hold.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			case (rx_mode)
				0: m_axis_tready <= 1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		vertex_t v;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (vertex_q.size() == 0) begin
				$error("point transaction with nothing expected: x=%h y=%h",
					m_axis_tdata[31:0], m_axis_tdata[63:32]);
				fail_count++;
			end else begin
				v = vertex_q.pop_front();
				if (m_axis_tdata[31:0] !== v.x) begin
					$error("point_x expected %h actual %h", v.x, m_axis_tdata[31:0]);
					fail_count++;
				end
				if (m_axis_tdata[63:32] !== v.y) begin
					$error("point_y expected %h actual %h", v.y, m_axis_tdata[63:32]);
					fail_count++;
				end
				if (m_axis_tlast !== v.last) begin
					$error("last_point expected %b actual %b", v.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t row;
		logic [5:0] phase_sections[$];
		phase_sections = '{6'd1, 6'd63, 6'd0, 6'd5, 6'd2, 6'($urandom_range(0, 63)),
			6'($urandom_range(0, 63)), 6'd16};

		// Equal angles counter-clockwise give the end point only; a zero angle lands on
		// center plus radius exactly, which makes overflow and its saturation easy to read off.
		rows.push_back('{'{32'sd0, 32'sd0, 31'h1_0000, 16'h0, 16'h0, 1'b0}, 1, 32'h1_0000, 32'h0});
		rows.push_back('{'{32'sh7FFF_FFFF, 32'sd5, 31'd1, 16'h0, 16'h0, 1'b0}, 1,
			32'h7FFF_FFFF, 32'd5});
		rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 31'd1, 16'h8000, 16'h8000, 1'b0}, 1,
			32'h8000_0000, 32'h8000_0000});
		rows.push_back('{'{32'sh1234_5678, -32'sd7, 31'd0, 16'hABCD, 16'hABCD, 1'b0}, 1,
			32'h1234_5678, 32'hFFFF_FFF9});
		rows.push_back('{'{32'sd100, 32'sd200, 31'd0, 16'h4000, 16'h4000, 1'b1}, 0, '0, '0});
		rows.push_back('{'{32'sd0, 32'sd0, 31'h7FFF_FFFF, 16'h0, 16'h0, 1'b1}, 0, '0, '0});
		rows.push_back('{'{32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF,
			1'b1}, 0, '0, '0});
		rows.push_back('{'{32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 16'h2000, 16'h6000,
			1'b0}, 0, '0, '0});
		rows.push_back('{'{32'sd0, 32'sd0, 31'h10_0000, 16'hFFFF, 16'h0000, 1'b0}, 0, '0, '0});
		rows.push_back('{'{32'sd0, 32'sd0, 31'h10_0000, 16'h0000, 16'hFFFF, 1'b0}, 0, '0, '0});
		rows.push_back('{'{32'sd0, 32'sd0, 31'h10_0000, 16'h0000, 16'hFFFF, 1'b1}, 0, '0, '0});
		rows.push_back('{'{32'sd0, 32'sd0, 31'h10_0000, 16'hFFFF, 16'h0000, 1'b1}, 0, '0, '0});
		rows.push_back('{'{-32'sd1, 32'sd1, 31'h5555_5555, 16'h1234, 16'h8765, 1'b0}, 0, '0, '0});
		rows.push_back('{'{32'sd1, -32'sd1, 31'h2AAA_AAAA, 16'h8765, 16'h1234, 1'b1}, 0, '0, '0});
		rows.push_back('{'{32'sh4000_0000, 32'shC000_0000, 31'h4000_0000, 16'h1000, 16'h1001,
			1'b1}, 0, '0, '0});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (rows[i])
			send_arc(rows[i]);

		foreach (phase_sections[p]) begin
			drain();
			write_sections(phase_sections[p]);
			for (int i = 0; i < 26; i++) begin
				// Hold the receiver off so the block fills and stalls its input.
				if (p == 3 && i == 2)
					rx_hold = 600;
				row.arc = random_arc();
				row.typed = 0;
				row.tx = '0;
				row.ty = '0;
				send_arc(row);
			end
		end

		s_axis_tvalid = 0;
		wait (vertex_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && vertex_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
